### rtl/tpnf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpnf_pkg - shared types and constants for the triangle pressure force block
// Request/response payloads, inter-stage structs and the fixed-point constants
// used by the scaling pipeline.
// ----------------------------------------------------------------------------
package tpnf_pkg;

   localparam int CoordW = 24;
   localparam int DiffW  = 25;
   localparam int ProdW  = 50;
   localparam int MagW   = 49;
   localparam int ForceW = 32;
   localparam int MaskW  = 9;

   typedef struct packed {
      logic signed [CoordW-1:0] v0_x;
      logic signed [CoordW-1:0] v0_y;
      logic signed [CoordW-1:0] v0_z;
      logic signed [CoordW-1:0] v1_x;
      logic signed [CoordW-1:0] v1_y;
      logic signed [CoordW-1:0] v1_z;
      logic signed [CoordW-1:0] v2_x;
      logic signed [CoordW-1:0] v2_y;
      logic signed [CoordW-1:0] v2_z;
      logic        [MaskW-1:0]  fixed_mask;
   } req_type;

   typedef struct packed {
      logic signed [ForceW-1:0] f0_x;
      logic signed [ForceW-1:0] f0_y;
      logic signed [ForceW-1:0] f0_z;
      logic signed [ForceW-1:0] f1_x;
      logic signed [ForceW-1:0] f1_y;
      logic signed [ForceW-1:0] f1_z;
      logic signed [ForceW-1:0] f2_x;
      logic signed [ForceW-1:0] f2_y;
      logic signed [ForceW-1:0] f2_z;
      logic                     saturated;
   } rsp_type;

   // one normal component as sign and magnitude
   typedef struct packed {
      logic            neg;
      logic [MagW-1:0] mag;
   } nrm_type;

   // one scaled force component
   typedef struct packed {
      logic [ForceW-1:0] value;
      logic              clip;
   } frc_type;

   // rounding offset: half of 6 * 2^20, expressed before the >> 21
   localparam logic [49:0] HalfDiv = 50'h30_0000;

   // t >= 3*(limit+1) means the quotient exceeds the limit
   localparam logic [52:0] PosSatLimit = 53'h1_8000_0000;
   localparam logic [52:0] NegSatLimit = 53'h1_8000_0003;

   // ceil(2^35 / 3), exact quotient for t < 2^35
   localparam logic [33:0] RecipThird = 34'h2_AAAA_AAAB;

   localparam logic [ForceW-1:0] PosClip = 32'h7FFF_FFFF;
   localparam logic [ForceW-1:0] NegClip = 32'h8000_0000;

   // register stages ahead of the output register
   localparam int StageCnt = 6;

endpackage
`default_nettype wire

### rtl/tpnf_cross.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpnf_cross - edge vectors and cross product
// Three register stages: edge differences, partial products, then the normal
// components as sign and magnitude.
// ----------------------------------------------------------------------------
module tpnf_cross (
   input  logic                       clock,
   input  logic                       enable,
   input  tpnf_pkg::req_type          req_data,
   output tpnf_pkg::nrm_type [2:0]    nrm
);
   import tpnf_pkg::*;

   logic signed [DiffW-1:0] d1_ff [3];
   logic signed [DiffW-1:0] d2_ff [3];
   logic signed [DiffW-1:0] d1_in [3];
   logic signed [DiffW-1:0] d2_in [3];
   logic signed [ProdW-1:0] pa_ff [3];
   logic signed [ProdW-1:0] pb_ff [3];
   logic signed [ProdW-1:0] pa_in [3];
   logic signed [ProdW-1:0] pb_in [3];
   nrm_type     [2:0]       nrm_ff;
   nrm_type     [2:0]       nrm_in;

   always_comb begin
      d1_in[0] = {req_data.v0_x[CoordW-1], req_data.v0_x}
               - {req_data.v1_x[CoordW-1], req_data.v1_x};
      d1_in[1] = {req_data.v0_y[CoordW-1], req_data.v0_y}
               - {req_data.v1_y[CoordW-1], req_data.v1_y};
      d1_in[2] = {req_data.v0_z[CoordW-1], req_data.v0_z}
               - {req_data.v1_z[CoordW-1], req_data.v1_z};
      d2_in[0] = {req_data.v0_x[CoordW-1], req_data.v0_x}
               - {req_data.v2_x[CoordW-1], req_data.v2_x};
      d2_in[1] = {req_data.v0_y[CoordW-1], req_data.v0_y}
               - {req_data.v2_y[CoordW-1], req_data.v2_y};
      d2_in[2] = {req_data.v0_z[CoordW-1], req_data.v0_z}
               - {req_data.v2_z[CoordW-1], req_data.v2_z};
   end

   always_comb begin
      pa_in[0] = ProdW'(d1_ff[1]) * ProdW'(d2_ff[2]);
      pb_in[0] = ProdW'(d1_ff[2]) * ProdW'(d2_ff[1]);
      pa_in[1] = ProdW'(d1_ff[2]) * ProdW'(d2_ff[0]);
      pb_in[1] = ProdW'(d1_ff[0]) * ProdW'(d2_ff[2]);
      pa_in[2] = ProdW'(d1_ff[0]) * ProdW'(d2_ff[1]);
      pb_in[2] = ProdW'(d1_ff[1]) * ProdW'(d2_ff[0]);
   end

   always_comb begin
      logic signed [ProdW-1:0] n;
      logic        [ProdW-1:0] abs_n;
      n     = '0;
      abs_n = '0;
      for (int k = 0; k < 3; k++) begin
         n     = pa_ff[k] - pb_ff[k];
         abs_n = n[ProdW-1] ? ProdW'(-n) : ProdW'(n);
         nrm_in[k].neg = n[ProdW-1];
         nrm_in[k].mag = abs_n[MagW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < 3; k++) begin
            d1_ff[k] <= d1_in[k];
            d2_ff[k] <= d2_in[k];
            pa_ff[k] <= pa_in[k];
            pb_ff[k] <= pb_in[k];
         end
         nrm_ff <= nrm_in;
      end
   end

   assign nrm = nrm_ff;

endmodule
`default_nettype wire

### rtl/tpnf_scale.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpnf_scale - pressure scaling of one normal component
// Three register stages: split product with |pressure|, rounding shift,
// saturation compare and reciprocal multiply for the divide by three.
// ----------------------------------------------------------------------------
module tpnf_scale (
   input  logic                        clock,
   input  logic                        enable,
   input  logic signed [23:0]          pressure,
   input  tpnf_pkg::nrm_type           nrm,
   output tpnf_pkg::frc_type           frc
);
   import tpnf_pkg::*;

   logic              p_neg;
   logic [CoordW-1:0] p_mag;

   logic [47:0] hi_ff,  hi_in;
   logic [48:0] lo_ff,  lo_in;
   logic        neg_d_ff;
   logic [49:0] lo_rnd;
   logic [52:0] t_ff,   t_in;
   logic        neg_e_ff;
   logic [49:0] ph_ff,  ph_in;
   logic [49:0] pl_ff,  pl_in;
   logic        neg_f_ff;
   logic        clip_ff, clip_in;
   logic [66:0] prod_sum;
   logic [ForceW-1:0] quot;

   assign p_neg = pressure[CoordW-1];
   assign p_mag = p_neg ? CoordW'(-pressure) : CoordW'(pressure);

   // magnitude split at bit 25 keeps each multiply within 25x24
   assign hi_in = 48'(nrm.mag[MagW-1:25]) * 48'(p_mag);
   assign lo_in = 49'(nrm.mag[24:0]) * 49'(p_mag);

   assign lo_rnd = {1'b0, lo_ff} + HalfDiv;
   assign t_in   = {1'b0, hi_ff, 4'b0000} + 53'(lo_rnd[49:21]);

   assign clip_in = neg_e_ff ? (t_ff >= NegSatLimit) : (t_ff >= PosSatLimit);
   // when not clipped t fits in 33 bits
   assign ph_in   = 50'(t_ff[32:0]) * 50'(RecipThird[33:17]);
   assign pl_in   = 50'(t_ff[32:0]) * 50'(RecipThird[16:0]);

   always_ff @(posedge clock) begin
      if (enable) begin
         hi_ff    <= hi_in;
         lo_ff    <= lo_in;
         neg_d_ff <= ~(p_neg ^ nrm.neg);
         t_ff     <= t_in;
         neg_e_ff <= neg_d_ff;
         ph_ff    <= ph_in;
         pl_ff    <= pl_in;
         neg_f_ff <= neg_e_ff;
         clip_ff  <= clip_in;
      end
   end

   assign prod_sum = {ph_ff, 17'b0} + 67'(pl_ff);
   assign quot     = prod_sum[66:35];

   always_comb begin
      frc.clip = clip_ff;
      if (clip_ff) begin
         frc.value = neg_f_ff ? NegClip : PosClip;
      end else begin
         frc.value = neg_f_ff ? ForceW'(-quot) : quot;
      end
   end

endmodule
`default_nettype wire

### rtl/triangle_pressure_nodal_forces.sv
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_pressure_nodal_forces - nodal pressure forces of a linear triangle
// Throughput: one request per cycle; the whole pipeline holds while the
// output register is full and rsp_ready is low.
// Reset clears all stage valid bits, the output valid and pressure to zero.
// ----------------------------------------------------------------------------
module triangle_pressure_nodal_forces (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  tpnf_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output tpnf_pkg::rsp_type  rsp_data,
   input  logic               csr_write_en,
   input  logic signed [23:0] csr_write_data
);
   import tpnf_pkg::*;

   logic signed [CoordW-1:0] pressure_ff;
   logic [StageCnt-1:0]      vld_ff;
   logic [MaskW-1:0]         mask_ff [StageCnt];
   logic                     rsp_vld_ff;
   rsp_type                  rsp_ff, rsp_in;
   logic                     pipe_en;
   nrm_type [2:0]            nrm;
   frc_type                  frc [3];
   logic [MaskW-1:0]         clip_map;
   logic                     clip_seen;

   assign pipe_en   = ~rsp_vld_ff | rsp_ready;
   assign req_ready = pipe_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         pressure_ff <= '0;
      end else if (csr_write_en) begin
         pressure_ff <= csr_write_data;
      end
   end

   tpnf_cross u_cross (
      .clock    (clock),
      .enable   (pipe_en),
      .req_data (req_data),
      .nrm      (nrm)
   );

   for (genvar k = 0; k < 3; k++) begin : g_scale
      tpnf_scale u_scale (
         .clock    (clock),
         .enable   (pipe_en),
         .pressure (pressure_ff),
         .nrm      (nrm[k]),
         .frc      (frc[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else if (pipe_en) begin
         vld_ff     <= {vld_ff[StageCnt-2:0], req_valid};
         rsp_vld_ff <= vld_ff[StageCnt-1];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         mask_ff[0] <= req_data.fixed_mask;
         for (int s = 1; s < StageCnt; s++) begin
            mask_ff[s] <= mask_ff[s-1];
         end
         rsp_ff <= rsp_in;
      end
   end

   // bit 3*vertex+axis: every vertex shares the same clip per axis
   assign clip_map = {3{frc[2].clip, frc[1].clip, frc[0].clip}};

   always_comb begin
      logic [MaskW-1:0] fm;
      fm = mask_ff[StageCnt-1];
      rsp_in.f0_x = fm[0] ? '0 : frc[0].value;
      rsp_in.f0_y = fm[1] ? '0 : frc[1].value;
      rsp_in.f0_z = fm[2] ? '0 : frc[2].value;
      rsp_in.f1_x = fm[3] ? '0 : frc[0].value;
      rsp_in.f1_y = fm[4] ? '0 : frc[1].value;
      rsp_in.f1_z = fm[5] ? '0 : frc[2].value;
      rsp_in.f2_x = fm[6] ? '0 : frc[0].value;
      rsp_in.f2_y = fm[7] ? '0 : frc[1].value;
      rsp_in.f2_z = fm[8] ? '0 : frc[2].value;
      rsp_in.saturated = |(~fm & clip_map);
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   assign clip_seen = (rsp_ff.f0_x == PosClip) || (rsp_ff.f0_x == NegClip)
                   || (rsp_ff.f0_y == PosClip) || (rsp_ff.f0_y == NegClip)
                   || (rsp_ff.f0_z == PosClip) || (rsp_ff.f0_z == NegClip)
                   || (rsp_ff.f1_x == PosClip) || (rsp_ff.f1_x == NegClip)
                   || (rsp_ff.f1_y == PosClip) || (rsp_ff.f1_y == NegClip)
                   || (rsp_ff.f1_z == PosClip) || (rsp_ff.f1_z == NegClip)
                   || (rsp_ff.f2_x == PosClip) || (rsp_ff.f2_x == NegClip)
                   || (rsp_ff.f2_y == PosClip) || (rsp_ff.f2_y == NegClip)
                   || (rsp_ff.f2_z == PosClip) || (rsp_ff.f2_z == NegClip);

   // a stalled pipeline keeps its occupancy
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(vld_ff))
      else $error("pipeline valid bits moved during stall");

   // saturation flag only with a clipped component on the output
   a_sat_has_clip: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_ff.saturated) |-> clip_seen)
      else $error("saturated set without a clipped component");

   // zero pressure gives zero force on f0_x, f1_y and f2_z and no saturation
   a_zero_pressure: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && (pressure_ff == '0)) |->
         (rsp_ff.f0_x == '0) && (rsp_ff.f1_y == '0) && (rsp_ff.f2_z == '0)
         && !rsp_ff.saturated)
      else $error("nonzero force at zero pressure");

endmodule
`default_nettype wire
